@@ hdl/uccb_pkg.sv @@
// Shared types and constants for the serial command to bus bridge.
package uccb_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  // Command codes carried in byte 2 of a frame.
  localparam logic [7:0] CMD_WRITE = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h00;

  // Greeting sent after the start event.
  localparam logic [7:0] GREETING = 8'h5A;

  // Number of bytes in one frame and the width of a position within it.
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PosW       = $clog2(FrameBytes);
  localparam logic [PosW-1:0] LastPos = PosW'(FrameBytes - 1);

  // Kind of a result beat.
  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_HAND  = 2'd3
  } kind_e;

  // Command phase, one-hot.
  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_READ    = 4'b0100,
    PH_HANDED  = 4'b1000
  } phase_e;

  // Compact description of the result beats caused by one input beat.
  // Beat 0 and every beat other than the bus beat of a frame transmit a
  // byte of tx_word; beat 1 of a frame is the bus request or hand-over.
  typedef struct packed {
    logic [1:0]  last_idx;
    logic        is_frame;
    kind_e       kind2;
    logic [31:0] tx_word;
    logic [31:0] addr;
    logic [31:0] data;
  } job_t;

endpackage

@@ hdl/uccb_ctrl.sv @@
// Command state, frame store and job decode for each accepted input beat.
module uccb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       read_data_i,
  output logic              job_load_o,
  output uccb_pkg::job_t    job_o
);
  import uccb_pkg::*;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [7:0]      store_q [FrameBytes];
  logic            job_load;
  logic            store_we;
  logic [7:0]      cmd;
  logic [31:0]     frame_addr;
  logic [31:0]     frame_data;

  // Fields assembled from the frame; the last byte comes straight from the input.
  assign cmd        = store_q[2];
  assign frame_addr = {store_q[3], 8'h00, store_q[1], store_q[0]};
  assign frame_data = {rx_byte_i, store_q[6], store_q[5], store_q[4]};

  // Next state and the job for the current input beat.
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    job_load = 1'b0;
    store_we = 1'b0;
    job_o    = '0;
    unique case (req_type_i)
      REQ_START: begin
        if (phase_q == PH_START) begin
          job_load      = 1'b1;
          job_o.tx_word = {24'h000000, GREETING};
          phase_d       = PH_COLLECT;
        end
      end
      REQ_BYTE: begin
        if (phase_q == PH_COLLECT) begin
          store_we = 1'b1;
          if (pos_q != LastPos) begin
            pos_d = pos_q + 1'b1;
          end else begin
            pos_d          = '0;
            cnt_d          = cnt_q + 8'd1;
            job_load       = 1'b1;
            job_o.last_idx = 2'd1;
            job_o.is_frame = 1'b1;
            job_o.tx_word  = {24'h000000, cnt_q};
            priority if (cmd == CMD_WRITE) begin
              job_o.kind2 = KIND_WRITE;
              job_o.addr  = frame_addr;
              job_o.data  = frame_data;
            end else if (cmd == CMD_READ) begin
              job_o.kind2 = KIND_READ;
              job_o.addr  = frame_addr;
              phase_d     = PH_READ;
            end else begin
              job_o.kind2 = KIND_HAND;
              phase_d     = PH_HANDED;
            end
          end
        end
      end
      REQ_REPLY: begin
        if (phase_q == PH_READ) begin
          job_load       = 1'b1;
          job_o.last_idx = 2'd3;
          job_o.tx_word  = read_data_i;
          phase_d        = PH_COLLECT;
        end
      end
      default: begin
      end
    endcase
  end

  assign job_load_o = accept_i && job_load;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  // Frame bytes; contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    if (accept_i && store_we) begin
      store_q[pos_q] <= rx_byte_i;
    end
  end

  // Frame position only moves while collecting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> (phase_q == PH_COLLECT))
    else $error("frame position nonzero outside collecting phase");

endmodule

@@ hdl/uccb_emit.sv @@
// Job register and result register that send out one result beat per cycle while the output is not stalled.
module uccb_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_load_i,
  input  uccb_pkg::job_t job_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     out_kind_o,
  output logic [7:0]     tx_byte_o,
  output logic [31:0]    bus_addr_o,
  output logic [31:0]    bus_data_o,
  output logic           last_o
);
  import uccb_pkg::*;

  job_t        job_q;
  logic        job_valid_q;
  logic [1:0]  idx_q;
  logic        take;
  logic        emit;
  logic        done;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] data_q, data_d;
  logic        last_q, last_d;
  logic [7:0]  sel_byte;

  // The result register can take a beat when empty or being drained.
  assign take       = !out_valid_q || !out_stall_i;
  assign emit       = job_valid_q && take;
  assign done       = emit && (idx_q == job_q.last_idx);
  assign in_stall_o = job_valid_q && !done;

  // Byte of the transmit word for the current beat, least significant first.
  always_comb begin
    unique case (idx_q)
      2'd0: sel_byte = job_q.tx_word[7:0];
      2'd1: sel_byte = job_q.tx_word[15:8];
      2'd2: sel_byte = job_q.tx_word[23:16];
      default: sel_byte = job_q.tx_word[31:24];
    endcase
  end

  // Fields of the current result beat.
  always_comb begin
    last_d = (idx_q == job_q.last_idx);
    if (job_q.is_frame && idx_q == 2'd1) begin
      kind_d = job_q.kind2;
      tx_d   = 8'h00;
      addr_d = job_q.addr;
      data_d = job_q.data;
    end else begin
      kind_d = KIND_TX;
      tx_d   = sel_byte;
      addr_d = '0;
      data_d = '0;
    end
  end

  // Job control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (job_load_i) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (done) begin
      job_valid_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end
  end

  // Result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      tx_q   <= tx_d;
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign tx_byte_o   = tx_q;
  assign bus_addr_o  = addr_q;
  assign bus_data_o  = data_q;
  assign last_o      = last_q;

  // A new job never overwrites one with beats still to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> (!job_valid_q || done))
    else $error("job loaded over an unfinished job");

  // The beat index never runs past the last beat of the job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (idx_q <= job_q.last_idx))
    else $error("beat index beyond end of job");

  // A finished job with nothing new behind it leaves the job register empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !job_load_i) |=> !job_valid_q)
    else $error("job register still busy after its last beat");

endmodule

@@ hdl/uart_command_bus_bridge_unit.sv @@
// An input beat's job is registered, then each of its result beats in turn; the
// single result register sends one beat per cycle while the output is not
// stalled. Throughput: one input beat per cycle while each causes at most one
// result and the output is not stalled; one causing more holds the input.
// Reset: asynchronous, active low; clears the command phase, frame position and
// frame counter. Frame bytes are not cleared, so no clearing pass is needed.
module uart_command_bus_bridge_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] bus_addr_o,
  output logic [31:0] bus_data_o,
  output logic        last_o
);
  import uccb_pkg::*;

  logic accept;
  logic job_load;
  job_t job;

  // An input beat is taken when offered and not held off.
  assign accept = in_valid_i && !in_stall_o;

  uccb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .read_data_i (read_data_i),
    .job_load_o  (job_load),
    .job_o       (job)
  );

  uccb_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_load_i  (job_load),
    .job_i       (job),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .tx_byte_o   (tx_byte_o),
    .bus_addr_o  (bus_addr_o),
    .bus_data_o  (bus_data_o),
    .last_o      (last_o)
  );

endmodule
